// ----- rtl/core/nrs_pkg.sv -----
package nrs_pkg;

    localparam int DATA_W    = 32;
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int COEF_W    = 54;
    localparam int NUM_W     = 64;
    localparam int SSUM_W    = 36;

    localparam int MUL_A_W   = COEF_W;
    localparam int MUL_B_W   = 48;
    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = MUL_B_W / MUL_CHUNK;
    localparam int ACC_W     = MUL_A_W + MUL_B_W;
    localparam int PROD_TOP  = FRAC_W + NUM_W - 1;

    localparam int DIV_W     = NUM_W - FRAC_W;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int MAG_W     = DATA_W + 1;
    localparam logic [MAG_W-1:0] MAG_LIM     = MAG_W'(1) << (WORD_W - 1);
    localparam logic [MAG_W-1:0] MAG_MAX_POS = MAG_LIM - MAG_W'(1);

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << 32);
    localparam logic signed [COEF_W-1:0] COEF_TWO = COEF_W'(64'd1 << 33);

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SQ      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        MOP_CT0,
        MOP_CT1,
        MOP_CT2,
        MOP_T1,
        MOP_TD,
        MOP_T0
    } mul_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] q_sample;
        logic signed [DATA_W-1:0] s_sample;
        logic                     start_run;
    } nrs_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] u_value;
        logic                     saturated;
    } nrs_out_t;

    typedef struct packed {
        logic    load;
        logic    start_val;
        logic    start_second;
        logic    mul_load;
        logic    mul_step;
        logic    mul_store;
        mul_op_t mul_op;
        logic    div_load;
        logic    div_step;
        logic    div_finish;
        logic    commit;
    } nrs_cmd_t;

    typedef struct packed {
        logic div_skip;
    } nrs_stat_t;

endpackage

// ----- rtl/core/numerov_recurrence_step_core.sv -----
// Numerov step for u'' + q*u = s on a stream of grid points, signed Q16.16 samples and
// an unsigned Q0.32 h*h/12. One item in, one result out. The first two items of a run
// return the configured start values; every later item runs six products on one
// shared 54x16 multiplier, then a 32-step restoring divider (1 quotient bit per
// cycle), which is skipped on a zero divisor or an out-of-range quotient. An item is
// taken only once the block has finished the last one. A result register sits on the
// output, so the next item is taken while the last result waits; a finished result
// stays inside until that register is free. The configuration port is always ready
// and must only be written while the block is idle.
module numerov_recurrence_step_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  nrs_pkg::nrs_in_t               sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output nrs_pkg::nrs_out_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nrs_pkg::DATA_W-1:0]     cfg_data
);
    import nrs_pkg::*;

    nrs_cmd_t  cmd;
    nrs_stat_t stat;

    assign cfg_ready = 1'b1;

    nrs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .start_run    (sample.start_run),
        .sample_ready (sample_ready),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .stat         (stat),
        .cmd          (cmd)
    );

    nrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

// ----- rtl/core/nrs_datapath.sv -----
module nrs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nrs_pkg::DATA_W-1:0]     cfg_data,
    input  nrs_pkg::nrs_in_t               sample,
    input  nrs_pkg::nrs_cmd_t              cmd,
    output nrs_pkg::nrs_stat_t             stat,
    output nrs_pkg::nrs_out_t              result
);
    import nrs_pkg::*;

    function automatic logic [NUM_W:0] sat_add(input logic signed [NUM_W-1:0] a,
                                               input logic signed [NUM_W-1:0] b);
        logic [NUM_W:0] sum;
        sum = {a[NUM_W-1], a} + {b[NUM_W-1], b};
        if (sum[NUM_W] != sum[NUM_W-1]) begin
            return {1'b1, sum[NUM_W], {(NUM_W-1){~sum[NUM_W]}}};
        end
        return {1'b0, sum[NUM_W-1:0]};
    endfunction

    function automatic logic [DATA_W:0] clamp_word(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] m;
        logic             s;
        s = 1'b0;
        m = mag;
        if (neg) begin
            if (mag > MAG_LIM) begin
                s = 1'b1;
                m = MAG_LIM;
            end
            m = -m;
        end else if (mag > MAG_MAX_POS) begin
            s = 1'b1;
            m = MAG_MAX_POS;
        end
        return {s, m[DATA_W-1:0]};
    endfunction

    logic        [DATA_W-1:0]   h2_reg;
    logic signed [DATA_W-1:0]   sv1_reg;
    logic signed [DATA_W-1:0]   sv2_reg;
    logic signed [DATA_W-1:0]   u1_reg;
    logic signed [DATA_W-1:0]   u2_reg;
    logic signed [DATA_W-1:0]   q1_reg;
    logic signed [DATA_W-1:0]   q2_reg;
    logic signed [DATA_W-1:0]   s1_reg;
    logic signed [DATA_W-1:0]   s2_reg;

    logic signed [DATA_W-1:0]   q_cur_reg;
    logic signed [DATA_W-1:0]   s_cur_reg;
    logic signed [COEF_W-1:0]   c0_reg;
    logic signed [COEF_W-1:0]   c1_reg;
    logic signed [COEF_W-1:0]   c2_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic                       sat_reg;
    logic        [MUL_A_W-1:0]  mul_a_reg;
    logic        [MUL_B_W-1:0]  mul_b_reg;
    logic        [ACC_W-1:0]    mul_acc_reg;
    logic                       mul_neg_reg;
    logic        [DIV_W-1:0]    dv_reg;
    logic        [DIV_W-1:0]    rem_reg;
    logic        [DIV_STEPS-1:0] quo_reg;
    logic                       div_neg_reg;
    logic                       div_zero_reg;
    logic                       div_ovf_reg;
    logic        [DATA_W-1:0]   res_u_reg;
    logic                       res_sat_reg;
    nrs_out_t                   result_reg;

    logic signed [SSUM_W-1:0]   s1_ext;
    logic signed [SSUM_W-1:0]   ssum;
    logic signed [MUL_A_W-1:0]  op_a;
    logic signed [MUL_B_W-1:0]  op_b;
    logic        [MUL_A_W-1:0]  a_mag;
    logic        [MUL_B_W-1:0]  b_mag;
    logic        [MUL_A_W+MUL_CHUNK-1:0] mul_prod;
    logic                       mul_ovf;
    logic        [NUM_W-2:0]    mul_mag;
    logic signed [NUM_W-1:0]    mul_res;
    logic signed [COEF_W-1:0]   ct;
    logic signed [COEF_W-1:0]   ct_ten;
    logic signed [NUM_W-1:0]    add_b;
    logic        [NUM_W:0]      add_out;
    logic        [NUM_W-1:0]    num_mag;
    logic        [COEF_W-1:0]   c2_abs;
    logic        [DIV_W-1:0]    c2_mag;
    logic                       c2_zero;
    logic                       div_ovf;
    logic        [DIV_W:0]      trial;
    logic        [DIV_W:0]      trial_diff;
    logic                       trial_ge;
    logic signed [DATA_W-1:0]   start_word;
    logic        [MAG_W-1:0]    start_mag;
    logic        [DATA_W:0]     start_clamp;
    logic                       fin_neg;
    logic        [MAG_W-1:0]    fin_mag;
    logic        [DATA_W:0]     fin_clamp;

    always_comb
    begin
        s1_ext = SSUM_W'(s1_reg);
        ssum   = SSUM_W'(s_cur_reg) + (s1_ext <<< 3) + (s1_ext <<< 1) + SSUM_W'(s2_reg);
        case (cmd.mul_op)
            MOP_CT0:
            begin
                op_a = MUL_A_W'(h2_reg);
                op_b = MUL_B_W'(q2_reg);
            end
            MOP_CT1:
            begin
                op_a = MUL_A_W'(h2_reg);
                op_b = MUL_B_W'(q1_reg);
            end
            MOP_CT2:
            begin
                op_a = MUL_A_W'(h2_reg);
                op_b = MUL_B_W'(q_cur_reg);
            end
            MOP_T1:
            begin
                op_a = c1_reg;
                op_b = MUL_B_W'(u1_reg);
            end
            MOP_TD:
            begin
                op_a = MUL_A_W'(h2_reg);
                op_b = MUL_B_W'(ssum);
            end
            MOP_T0:
            begin
                op_a = c0_reg;
                op_b = MUL_B_W'(u2_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        a_mag = op_a[MUL_A_W-1] ? MUL_A_W'(-op_a) : MUL_A_W'(op_a);
        b_mag = op_b[MUL_B_W-1] ? MUL_B_W'(-op_b) : MUL_B_W'(op_b);
    end

    assign mul_prod = (MUL_A_W+MUL_CHUNK)'(mul_a_reg)
                    * (MUL_A_W+MUL_CHUNK)'(mul_b_reg[MUL_B_W-1 -: MUL_CHUNK]);

    assign mul_ovf = |mul_acc_reg[ACC_W-1:PROD_TOP];
    assign mul_mag = mul_ovf ? '1 : mul_acc_reg[PROD_TOP-1:FRAC_W];
    assign mul_res = mul_neg_reg ? -NUM_W'({1'b0, mul_mag}) : NUM_W'({1'b0, mul_mag});
    assign ct      = mul_res[COEF_W-1:0];
    assign ct_ten  = (ct <<< 3) + (ct <<< 1);
    assign add_b   = (cmd.mul_op == MOP_T0) ? -mul_res : mul_res;
    assign add_out = sat_add(num_reg, add_b);

    assign num_mag = num_reg[NUM_W-1] ? (NUM_W'(0) - NUM_W'(num_reg)) : NUM_W'(num_reg);
    assign c2_abs  = c2_reg[COEF_W-1] ? COEF_W'(-c2_reg) : COEF_W'(c2_reg);
    assign c2_mag  = c2_abs[DIV_W-1:0];
    assign c2_zero = (c2_reg == '0);
    assign div_ovf = (num_mag[NUM_W-1:FRAC_W] >= c2_mag);
    assign stat.div_skip = c2_zero | div_ovf;

    assign trial      = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign trial_diff = trial - {1'b0, dv_reg};
    assign trial_ge   = (trial >= {1'b0, dv_reg});

    assign start_word  = cmd.start_second ? sv2_reg : sv1_reg;
    assign start_mag   = start_word[DATA_W-1] ? (MAG_W'(0) - MAG_W'(start_word))
                                              : MAG_W'(start_word);
    assign start_clamp = clamp_word(start_word[DATA_W-1], start_mag);

    always_comb
    begin
        if (div_zero_reg) begin
            fin_neg = num_reg[NUM_W-1];
            fin_mag = (num_reg == '0) ? '0 : '1;
        end else if (div_ovf_reg) begin
            fin_neg = div_neg_reg;
            fin_mag = '1;
        end else begin
            fin_neg = div_neg_reg;
            fin_mag = {1'b0, quo_reg};
        end
        fin_clamp = clamp_word(fin_neg, fin_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            h2_reg  <= '0;
            sv1_reg <= '0;
            sv2_reg <= DATA_W'(655);
            u1_reg  <= '0;
            u2_reg  <= '0;
            q1_reg  <= '0;
            q2_reg  <= '0;
            s1_reg  <= '0;
            s2_reg  <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_STEP_SQ:      h2_reg  <= cfg_data;
                    CFG_START_FIRST:  sv1_reg <= cfg_data;
                    CFG_START_SECOND: sv2_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.commit) begin
                u2_reg <= u1_reg;
                u1_reg <= res_u_reg;
                q2_reg <= q1_reg;
                q1_reg <= q_cur_reg;
                s2_reg <= s1_reg;
                s1_reg <= s_cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            q_cur_reg <= sample.q_sample;
            s_cur_reg <= sample.s_sample;
            sat_reg   <= 1'b0;
        end
        if (cmd.start_val) begin
            res_u_reg   <= start_clamp[DATA_W-1:0];
            res_sat_reg <= start_clamp[DATA_W];
        end
        if (cmd.mul_load) begin
            mul_a_reg   <= a_mag;
            mul_b_reg   <= b_mag;
            mul_acc_reg <= '0;
            mul_neg_reg <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
        end
        if (cmd.mul_step) begin
            mul_acc_reg <= (mul_acc_reg << MUL_CHUNK) + ACC_W'(mul_prod);
            mul_b_reg   <= mul_b_reg << MUL_CHUNK;
        end
        if (cmd.mul_store) begin
            case (cmd.mul_op)
                MOP_CT0: c0_reg <= COEF_ONE + ct;
                MOP_CT1: c1_reg <= COEF_TWO - ct_ten;
                MOP_CT2: c2_reg <= COEF_ONE + ct;
                MOP_T1:
                begin
                    num_reg <= mul_res;
                    sat_reg <= sat_reg | mul_ovf;
                end
                MOP_TD, MOP_T0:
                begin
                    num_reg <= add_out[NUM_W-1:0];
                    sat_reg <= sat_reg | mul_ovf | add_out[NUM_W];
                end
                default: ;
            endcase
        end
        if (cmd.div_load) begin
            dv_reg       <= c2_mag;
            rem_reg      <= num_mag[NUM_W-1:FRAC_W];
            quo_reg      <= {num_mag[FRAC_W-1:0], {(DIV_STEPS-FRAC_W){1'b0}}};
            div_neg_reg  <= num_reg[NUM_W-1] ^ c2_reg[COEF_W-1];
            div_zero_reg <= c2_zero;
            div_ovf_reg  <= div_ovf;
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_STEPS-2:0], trial_ge};
        end
        if (cmd.div_finish) begin
            res_u_reg   <= fin_clamp[DATA_W-1:0];
            res_sat_reg <= sat_reg | div_zero_reg | div_ovf_reg | fin_clamp[DATA_W];
        end
        if (cmd.commit) begin
            result_reg.u_value   <= res_u_reg;
            result_reg.saturated <= res_sat_reg;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/core/nrs_ctrl.sv -----
module nrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic               start_run,
    output logic               sample_ready,
    input  logic               result_ready,
    output logic               result_valid,
    input  nrs_pkg::nrs_stat_t stat,
    output nrs_pkg::nrs_cmd_t  cmd
);
    import nrs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_MUL_STORE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_ONE,
        RUN_MORE
    } run_pos_t;

    state_t           state_reg;
    run_pos_t         run_pos_reg;
    mul_op_t          op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             result_valid_reg;
    logic             out_free;

    assign out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            run_pos_reg      <= RUN_NONE;
            op_reg           <= MOP_CT0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_COMMIT && out_free) begin
                result_valid_reg <= 1'b1;
            end else if (result_valid_reg && result_ready) begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid) begin
                        if (start_run || run_pos_reg == RUN_NONE) begin
                            run_pos_reg <= RUN_ONE;
                            state_reg   <= ST_START;
                        end else if (run_pos_reg == RUN_ONE) begin
                            run_pos_reg <= RUN_MORE;
                            state_reg   <= ST_START;
                        end else begin
                            op_reg    <= MOP_CT0;
                            state_reg <= ST_MUL_LOAD;
                        end
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_MUL_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL_RUN;
                end
                ST_MUL_RUN:
                begin
                    if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                        state_reg <= ST_MUL_STORE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_MUL_STORE:
                begin
                    state_reg <= ST_MUL_LOAD;
                    case (op_reg)
                        MOP_CT0: op_reg <= MOP_CT1;
                        MOP_CT1: op_reg <= MOP_CT2;
                        MOP_CT2: op_reg <= MOP_T1;
                        MOP_T1:  op_reg <= MOP_TD;
                        MOP_TD:  op_reg <= MOP_T0;
                        default: state_reg <= ST_DIV_LOAD;
                    endcase
                end
                ST_DIV_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= stat.div_skip ? ST_DIV_DONE : ST_DIV_RUN;
                end
                ST_DIV_RUN:
                begin
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_DIV_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DIV_DONE:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd              = '0;
        cmd.load         = (state_reg == ST_IDLE) && sample_valid;
        cmd.start_val    = (state_reg == ST_START);
        cmd.start_second = (run_pos_reg == RUN_MORE);
        cmd.mul_load     = (state_reg == ST_MUL_LOAD);
        cmd.mul_step     = (state_reg == ST_MUL_RUN);
        cmd.mul_store    = (state_reg == ST_MUL_STORE);
        cmd.mul_op       = op_reg;
        cmd.div_load     = (state_reg == ST_DIV_LOAD);
        cmd.div_step     = (state_reg == ST_DIV_RUN);
        cmd.div_finish   = (state_reg == ST_DIV_DONE);
        cmd.commit       = (state_reg == ST_COMMIT) && out_free;
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// ----- rtl/core/nrs_checker.sv -----
module nrs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_ready,
    input logic              result_valid,
    input logic              result_ready,
    input nrs_pkg::nrs_out_t result
);

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready ##1 !sample_ready)
        else $error("block took a new item too soon after the last one");

    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> sample_ready && !$past(sample_ready))
        else $error("result appeared without the block finishing an item");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready && !sample_valid |=> !$rose(result_valid))
        else $error("idle block produced a result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result dropped or changed");

endmodule

bind numerov_recurrence_step_core nrs_checker u_nrs_checker (.*);

// ----- dv/numerov_recurrence_step_core_tb.sv -----
module numerov_recurrence_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] UNIT    = 64'sh0000_0001_0000_0000;

    localparam logic signed [31:0] V_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] V_ONE   = 32'sh0001_0000;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 250;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     sample_valid = 1'b0;
    logic     sample_ready;
    nrs_in_t  sample = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    nrs_out_t result;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    logic [31:0]        h2_reg = '0;
    logic signed [31:0] first_reg = '0;
    logic signed [31:0] second_reg = 32'sd655;

    logic signed [31:0] u_hist1 = '0, u_hist2 = '0;
    logic signed [31:0] q_hist1 = '0, q_hist2 = '0;
    logic signed [31:0] s_hist1 = '0, s_hist2 = '0;
    int                 run_pos = 0;
    logic               step_sat;

    nrs_out_t u_expected[$];
    int       mismatch_count = 0;
    bit       steady = 1'b0;

    numerov_recurrence_step_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 24);
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] x);
        return x[63] ? -x : x;
    endfunction

    function automatic logic signed [63:0] clamp_word(input logic neg, input logic [63:0] m);
        logic [63:0] lim;
        lim = 64'd1 << (WORD_W - 1);
        if (neg) begin
            if (m > lim) begin
                step_sat = 1'b1;
                m = lim;
            end
            return -$signed(m);
        end
        if (m > lim - 64'd1) begin
            step_sat = 1'b1;
            m = lim - 64'd1;
        end
        return $signed(m);
    endfunction

    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b);
        logic [127:0] full;
        logic [63:0]  val;
        full = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        if (full[127:79] != '0) begin
            step_sat = 1'b1;
            val = I64_MAX;
        end
        else
        begin
            val = full[79:16];
        end
        return (a[63] != b[63]) ? -$signed(val) : $signed(val);
    endfunction

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] total;
        total = $signed({a[63], a}) + $signed({b[63], b});
        if (total[64] != total[63]) begin
            step_sat = 1'b1;
            return total[64] ? I64_MIN : I64_MAX;
        end
        return total[63:0];
    endfunction

    function automatic logic signed [63:0] h2_times(input logic signed [31:0] q);
        logic signed [63:0] p;
        p = $signed({32'd0, h2_reg}) * q;
        return p / 64'sd65536;
    endfunction

    function automatic nrs_out_t numerov_next(input nrs_in_t item);
        logic signed [63:0] q, s, c0, c1, c2, ssum, t0, t1, td, num, u;
        logic [63:0]        nm, dv, quo, rem, m;
        nrs_out_t           r;
        q = item.q_sample;
        s = item.s_sample;
        step_sat = 1'b0;
        if (item.start_run || run_pos == 0) begin
            u = clamp_word(first_reg[31], magnitude(first_reg));
            run_pos = 1;
        end
        else if (run_pos == 1) begin
            u = clamp_word(second_reg[31], magnitude(second_reg));
            run_pos = 2;
        end
        else
        begin
            c0 = UNIT + h2_times(q_hist2);
            c1 = 2 * UNIT - 64'sd10 * h2_times(q_hist1);
            c2 = UNIT + h2_times(q[31:0]);
            ssum = s + 64'sd10 * s_hist1 + s_hist2;
            t1 = scaled_product(c1, u_hist1);
            td = scaled_product($signed({32'd0, h2_reg}), ssum);
            t0 = scaled_product(c0, u_hist2);
            num = sat_sum(sat_sum(t1, td), -t0);
            if (c2 == 0) begin
                step_sat = 1'b1;
                if (num > 0)
                    u = clamp_word(1'b0, '1);
                else if (num < 0)
                    u = clamp_word(1'b1, '1);
                else
                    u = '0;
            end
            else
            begin
                nm = magnitude(num);
                dv = magnitude(c2);
                quo = nm / dv;
                rem = nm % dv;
                if (quo >= (64'd1 << 47)) begin
                    step_sat = 1'b1;
                    m = '1;
                end
                else
                begin
                    m = (quo << FRAC_W) | ((rem << FRAC_W) / dv);
                end
                u = clamp_word(num[63] != c2[63], m);
            end
        end
        u_hist2 = u_hist1;
        u_hist1 = u[31:0];
        q_hist2 = q_hist1;
        q_hist1 = item.q_sample;
        s_hist2 = s_hist1;
        s_hist1 = item.s_sample;
        r.u_value = u[31:0];
        r.saturated = step_sat;
        return r;
    endfunction

    task automatic send_point(input logic signed [31:0] q, input logic signed [31:0] s,
                              input logic start);
        nrs_in_t item;
        item.q_sample = q;
        item.s_sample = s;
        item.start_run = start;
        while (take_break()) begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= item;
        do @(posedge clk); while (!sample_ready);
        u_expected.push_back(numerov_next(item));
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        do @(posedge clk); while (u_expected.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_STEP_SQ:      h2_reg = value;
            CFG_START_FIRST:  first_reg = value;
            CFG_START_SECOND: second_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] h2, input logic signed [31:0] first,
                             input logic signed [31:0] second);
        wait_drained();
        write_reg(CFG_STEP_SQ, h2);
        write_reg(CFG_START_FIRST, first);
        write_reg(CFG_START_SECOND, second);
        write_reg(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // no start flag yet: the first item must still open a run
    task automatic test_no_run_yet();
        send_point(32'sd5, 32'sd7, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(V_ONE, V_ONE, 1'b0);
        send_point(-32'sd1, -32'sd1, 1'b0);
    endtask

    task automatic test_field_extremes();
        configure(32'hFFFF_FFFF, V_MAX, V_MIN);
        send_point(V_MIN, V_MAX, 1'b1);
        send_point(V_MAX, V_MIN, 1'b0);
        send_point(V_MIN, V_MAX, 1'b0);
        send_point(V_MAX, V_MIN, 1'b0);
        send_point(32'sd0, -32'sd1, 1'b0);
        send_point(-32'sd1, 32'sd0, 1'b0);
    endtask

    // h2 = 0.5 and q = -2.0 cancel the divisor exactly
    task automatic test_zero_divisor();
        configure(32'h8000_0000, 32'sd0, V_ONE);
        send_point(32'sd0, 32'sd0, 1'b1);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(-32'sd131072, 32'sd0, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b1);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(-32'sd131072, -32'sd262144, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b1);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(-32'sd131072, V_MIN, 1'b0);
    endtask

    // tiny and negative divisors
    task automatic test_quotient_clamp();
        send_point(32'sd0, 32'sd0, 1'b1);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(-32'sd131071, 32'sd0, 1'b0);
        send_point(-32'sd262144, V_MAX, 1'b0);
    endtask

    task automatic test_restart();
        configure(32'h0000_8000, V_MIN, V_MAX);
        send_point(32'sd7, 32'sd7, 1'b1);
        send_point(32'sd3, 32'sd3, 1'b1);
        send_point(32'sd1, 32'sd1, 1'b0);
        send_point(32'sd2, 32'sd2, 1'b1);
    endtask

    task automatic test_random_runs();
        logic [31:0]        h2;
        logic signed [31:0] q, s, first, second;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       h2 = $urandom_range(1, 1 << 20);
                2:       h2 = '0;
                3:       h2 = 32'hFFFF_FFFF;
                4:       h2 = $urandom_range(1, 1 << 16);
                default: h2 = $urandom;
            endcase
            first = $signed($urandom) >>> $urandom_range(31);
            second = $signed($urandom) >>> $urandom_range(31);
            configure(h2, first, second);
            steady = (phase == 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                q = $signed($urandom) >>> $urandom_range(31);
                s = $signed($urandom) >>> $urandom_range(31);
                send_point(q, s, $urandom_range(31) == 0);
            end
            steady = 1'b0;
        end
    endtask

    always @(posedge clk) begin
        nrs_out_t want;
        if (rst_n && result_valid && result_ready) begin
            if (u_expected.size() == 0) begin
                $display("%0t: unexpected result u_value %h saturated %b",
                         $time, result.u_value, result.saturated);
                mismatch_count++;
            end
            else
            begin
                want = u_expected.pop_front();
                if (result.u_value !== want.u_value) begin
                    $display("%0t: u_value expected %h got %h",
                             $time, want.u_value, result.u_value);
                    mismatch_count++;
                end
                if (result.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b got %b",
                             $time, want.saturated, result.saturated);
                    mismatch_count++;
                end
            end
        end
        result_ready <= steady || ($urandom_range(99) >= 24);
    end

    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_run_yet();
        test_field_extremes();
        test_zero_divisor();
        test_quotient_clamp();
        test_restart();
        test_random_runs();
        wait_drained();
        repeat (100) @(posedge clk);
        if (u_expected.size() != 0) begin
            $display("%0t: %0d results missing", $time, u_expected.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
